### rtl/core/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, reset included.
`define SIC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on every rising edge while reset is released.
`define SIC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### rtl/core/sic_pkg.sv
// Widths, codes and stage payload types of the segment intersection classifier.
`default_nettype none

package sic_pkg;

    localparam int COORD_BITS = 16;

    // coordinate differences and cross products
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MAG_W  = COORD_BITS;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DEN_W  = PROD_W + 1;
    localparam int DMAG_W = 2 * COORD_BITS + 1;

    // split of the numerator magnitude for the offset multiply
    localparam int LO_W = (DMAG_W + 1) / 2;
    localparam int HI_W = DMAG_W - LO_W;
    localparam int UP_W = MAG_W + DMAG_W;

    // divider: quotient clamps at 2**QB, far beyond the saturated range
    localparam int QB         = COORD_BITS + 1;
    localparam int DIV_W      = UP_W + 2;
    localparam int DD_W       = DMAG_W + 1;
    localparam int Q_W        = QB + 1;
    localparam int DIV_STAGES = QB + 1;
    localparam int SUM_W      = Q_W + 2;

    localparam int IN_DATA_W  = ((8 * COORD_BITS + 2 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 2 + 7) / 8) * 8;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_NONE   = 2'd0;
    localparam t_mode MODE_WITHIN = 2'd1;
    localparam t_mode MODE_ALWAYS = 2'd2;

    typedef enum logic [1:0] {
        CLS_NONE    = 2'd0,
        CLS_HIT     = 2'd1,
        CLS_OUTSIDE = 2'd2
    } t_hit_class;

    typedef struct packed {
        t_hit_class                     cls;
        logic                           give;
        logic                           neg_x;
        logic                           neg_y;
        logic signed [COORD_BITS-1:0]   ax1;
        logic signed [COORD_BITS-1:0]   ay1;
    } t_ctl;

    typedef struct packed {
        logic [MAG_W-1:0]  ax_mag;
        logic [MAG_W-1:0]  ay_mag;
        logic [DMAG_W-1:0] num_mag;
        logic [DMAG_W-1:0] den_mag;
    } t_mag;

endpackage

`default_nettype wire

### rtl/core/segment_intersection_classifier.sv
// Throughput: one segment pair per cycle while the output is not stalled;
// the 18-stage divider pipeline is fully overlapped.
// A stalled result parks in a skid register; o_s_tready drops only while it is occupied.
// Reset: synchronous, active low; clears every valid bit, those of the output and skid registers too.
// Top level: 2D segment intersection classifier with clamped Q12.4 intersection point.
`default_nettype none

module segment_intersection_classifier (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2, point_mode, zero pad
    input  wire logic [sic_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // hit_class, point_x, point_y, zero pad
    output logic [sic_pkg::OUT_DATA_W-1:0]          o_m_tdata
);

    logic                           en;

    logic                           front_valid;
    sic_pkg::t_ctl                  front_ctl;
    sic_pkg::t_mag                  front_mag;

    logic                           scale_valid;
    sic_pkg::t_ctl                  scale_ctl;
    logic [sic_pkg::DIV_W-1:0]      scale_nx, scale_ny;
    logic [sic_pkg::DD_W-1:0]       scale_dd;

    logic                           div_valid;
    sic_pkg::t_ctl                  div_ctl;
    logic [sic_pkg::Q_W-1:0]        div_qx, div_qy;

    sic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (front_valid),
        .o_ctl   (front_ctl),
        .o_mag   (front_mag)
    );

    sic_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_ctl   (front_ctl),
        .i_mag   (front_mag),
        .o_valid (scale_valid),
        .o_ctl   (scale_ctl),
        .o_nx    (scale_nx),
        .o_ny    (scale_ny),
        .o_dd    (scale_dd)
    );

    sic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (scale_valid),
        .i_ctl   (scale_ctl),
        .i_nx    (scale_nx),
        .i_ny    (scale_ny),
        .i_dd    (scale_dd),
        .o_valid (div_valid),
        .o_ctl   (div_ctl),
        .o_qx    (div_qx),
        .o_qy    (div_qy)
    );

    sic_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (div_valid),
        .i_ctl      (div_ctl),
        .i_qx       (div_qx),
        .i_qy       (div_qy),
        .i_m_tready (i_m_tready),
        .o_en       (en),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    assign o_s_tready = en;

endmodule

`default_nettype wire

### rtl/core/sic_front.sv
// Front stages: differences, cross products, denominator and classification.
`default_nettype none

module sic_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic                               i_valid,
    input  wire logic [sic_pkg::IN_DATA_W-1:0]      i_data,
    output logic                                    o_valid,
    output sic_pkg::t_ctl                           o_ctl,
    output sic_pkg::t_mag                           o_mag
);

    function automatic logic signed [sic_pkg::DIFF_W-1:0] sext_c(
        input logic [sic_pkg::COORD_BITS-1:0] v
    );
        return {v[sic_pkg::COORD_BITS-1], v};
    endfunction

    function automatic logic in_unit(
        input logic signed [sic_pkg::DEN_W-1:0] num,
        input logic signed [sic_pkg::DEN_W-1:0] den
    );
        if (den > 0) begin
            return (num >= 0) && (num <= den);
        end
        return (num <= 0) && (num >= den);
    endfunction

    logic [sic_pkg::COORD_BITS-1:0] f_ax1, f_ay1, f_ax2, f_ay2;
    logic [sic_pkg::COORD_BITS-1:0] f_bx1, f_by1, f_bx2, f_by2;
    sic_pkg::t_mode                 f_mode;

    assign f_ax1  = i_data[0*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_ay1  = i_data[1*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_ax2  = i_data[2*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_ay2  = i_data[3*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_bx1  = i_data[4*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_by1  = i_data[5*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_bx2  = i_data[6*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_by2  = i_data[7*sic_pkg::COORD_BITS +: sic_pkg::COORD_BITS];
    assign f_mode = i_data[8*sic_pkg::COORD_BITS +: 2];

    // stage 1: differences
    logic                                   r_v1;
    logic signed [sic_pkg::DIFF_W-1:0]      r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [sic_pkg::COORD_BITS-1:0]  r1_ax1, r1_ay1;
    sic_pkg::t_mode                         r1_mode;

    // stage 2: cross products
    logic                                   r_v2;
    logic signed [sic_pkg::PROD_W-1:0]      r2_aybx, r2_axby, r2_bycx, r2_bxcy;
    logic signed [sic_pkg::PROD_W-1:0]      r2_axcy, r2_aycx;
    logic signed [sic_pkg::DIFF_W-1:0]      r2_ax, r2_ay;
    logic signed [sic_pkg::COORD_BITS-1:0]  r2_ax1, r2_ay1;
    sic_pkg::t_mode                         r2_mode;

    // stage 3: denominator and numerators
    logic                                   r_v3;
    logic signed [sic_pkg::DEN_W-1:0]       r3_den, r3_num_a, r3_num_b;
    logic signed [sic_pkg::DIFF_W-1:0]      r3_ax, r3_ay;
    logic signed [sic_pkg::COORD_BITS-1:0]  r3_ax1, r3_ay1;
    sic_pkg::t_mode                         r3_mode;

    // stage 4: class, signs and magnitudes
    logic                                   r_v4;
    sic_pkg::t_ctl                          r4_ctl;
    sic_pkg::t_mag                          r4_mag;
    sic_pkg::t_ctl                          n4_ctl;
    sic_pkg::t_mag                          n4_mag;

    always_comb begin
        logic signed [sic_pkg::DEN_W-1:0]  den_abs;
        logic signed [sic_pkg::DEN_W-1:0]  num_abs;
        logic signed [sic_pkg::DIFF_W-1:0] ax_abs;
        logic signed [sic_pkg::DIFF_W-1:0] ay_abs;
        logic                              in_both;

        den_abs = r3_den[sic_pkg::DEN_W-1] ? -r3_den : r3_den;
        num_abs = r3_num_a[sic_pkg::DEN_W-1] ? -r3_num_a : r3_num_a;
        ax_abs  = r3_ax[sic_pkg::DIFF_W-1] ? -r3_ax : r3_ax;
        ay_abs  = r3_ay[sic_pkg::DIFF_W-1] ? -r3_ay : r3_ay;
        in_both = in_unit(r3_num_a, r3_den) && in_unit(r3_num_b, r3_den);

        n4_ctl.ax1   = r3_ax1;
        n4_ctl.ay1   = r3_ay1;
        n4_ctl.neg_x = r3_ax[sic_pkg::DIFF_W-1] ^ r3_num_a[sic_pkg::DEN_W-1]
                     ^ r3_den[sic_pkg::DEN_W-1];
        n4_ctl.neg_y = r3_ay[sic_pkg::DIFF_W-1] ^ r3_num_a[sic_pkg::DEN_W-1]
                     ^ r3_den[sic_pkg::DEN_W-1];
        if (r3_den == '0) begin
            n4_ctl.cls  = sic_pkg::CLS_NONE;
            n4_ctl.give = 1'b0;
        end else begin
            n4_ctl.cls = in_both ? sic_pkg::CLS_HIT : sic_pkg::CLS_OUTSIDE;
            case (r3_mode)
                sic_pkg::MODE_NONE:   n4_ctl.give = 1'b0;
                sic_pkg::MODE_ALWAYS: n4_ctl.give = 1'b1;
                default:              n4_ctl.give = in_both;
            endcase
        end

        n4_mag.ax_mag  = ax_abs[sic_pkg::MAG_W-1:0];
        n4_mag.ay_mag  = ay_abs[sic_pkg::MAG_W-1:0];
        n4_mag.num_mag = num_abs[sic_pkg::DMAG_W-1:0];
        n4_mag.den_mag = den_abs[sic_pkg::DMAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax   <= sext_c(f_ax2) - sext_c(f_ax1);
            r1_ay   <= sext_c(f_ay2) - sext_c(f_ay1);
            r1_bx   <= sext_c(f_bx1) - sext_c(f_bx2);
            r1_by   <= sext_c(f_by1) - sext_c(f_by2);
            r1_cx   <= sext_c(f_ax1) - sext_c(f_bx1);
            r1_cy   <= sext_c(f_ay1) - sext_c(f_by1);
            r1_ax1  <= f_ax1;
            r1_ay1  <= f_ay1;
            r1_mode <= f_mode;

            r2_aybx <= r1_ay * r1_bx;
            r2_axby <= r1_ax * r1_by;
            r2_bycx <= r1_by * r1_cx;
            r2_bxcy <= r1_bx * r1_cy;
            r2_axcy <= r1_ax * r1_cy;
            r2_aycx <= r1_ay * r1_cx;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_ax1  <= r1_ax1;
            r2_ay1  <= r1_ay1;
            r2_mode <= r1_mode;

            r3_den   <= sic_pkg::DEN_W'(r2_aybx) - sic_pkg::DEN_W'(r2_axby);
            r3_num_a <= sic_pkg::DEN_W'(r2_bycx) - sic_pkg::DEN_W'(r2_bxcy);
            r3_num_b <= sic_pkg::DEN_W'(r2_axcy) - sic_pkg::DEN_W'(r2_aycx);
            r3_ax    <= r2_ax;
            r3_ay    <= r2_ay;
            r3_ax1   <= r2_ax1;
            r3_ay1   <= r2_ay1;
            r3_mode  <= r2_mode;

            r4_ctl <= n4_ctl;
            r4_mag <= n4_mag;
        end
    end

    assign o_valid = r_v4;
    assign o_ctl   = r4_ctl;
    assign o_mag   = r4_mag;

endmodule

`default_nettype wire

### rtl/core/sic_scale.sv
// Offset product stages: |a| * |num| in two partial products, then the rounding dividend.
`default_nettype none

module sic_scale (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire sic_pkg::t_ctl                  i_ctl,
    input  wire sic_pkg::t_mag                  i_mag,
    output logic                                o_valid,
    output sic_pkg::t_ctl                       o_ctl,
    output logic [sic_pkg::DIV_W-1:0]           o_nx,
    output logic [sic_pkg::DIV_W-1:0]           o_ny,
    output logic [sic_pkg::DD_W-1:0]            o_dd
);

    // stage 5: partial products
    logic                                           r_v5;
    logic [sic_pkg::MAG_W+sic_pkg::LO_W-1:0]        r5_xlo, r5_ylo;
    logic [sic_pkg::MAG_W+sic_pkg::HI_W-1:0]        r5_xhi, r5_yhi;
    logic [sic_pkg::DMAG_W-1:0]                     r5_den;
    sic_pkg::t_ctl                                  r5_ctl;

    // stage 6: full products
    logic                                           r_v6;
    logic [sic_pkg::UP_W-1:0]                       r6_upx, r6_upy;
    logic [sic_pkg::DMAG_W-1:0]                     r6_den;
    sic_pkg::t_ctl                                  r6_ctl;

    // stage 7: dividend 2|p| + |den| and divisor 2|den|
    logic                                           r_v7;
    logic [sic_pkg::DIV_W-1:0]                      r7_nx, r7_ny;
    logic [sic_pkg::DD_W-1:0]                       r7_dd;
    sic_pkg::t_ctl                                  r7_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_xlo <= i_mag.ax_mag * i_mag.num_mag[sic_pkg::LO_W-1:0];
            r5_xhi <= i_mag.ax_mag * i_mag.num_mag[sic_pkg::DMAG_W-1:sic_pkg::LO_W];
            r5_ylo <= i_mag.ay_mag * i_mag.num_mag[sic_pkg::LO_W-1:0];
            r5_yhi <= i_mag.ay_mag * i_mag.num_mag[sic_pkg::DMAG_W-1:sic_pkg::LO_W];
            r5_den <= i_mag.den_mag;
            r5_ctl <= i_ctl;

            r6_upx <= sic_pkg::UP_W'(r5_xlo) + (sic_pkg::UP_W'(r5_xhi) << sic_pkg::LO_W);
            r6_upy <= sic_pkg::UP_W'(r5_ylo) + (sic_pkg::UP_W'(r5_yhi) << sic_pkg::LO_W);
            r6_den <= r5_den;
            r6_ctl <= r5_ctl;

            r7_nx  <= sic_pkg::DIV_W'({r6_upx, 1'b0}) + sic_pkg::DIV_W'(r6_den);
            r7_ny  <= sic_pkg::DIV_W'({r6_upy, 1'b0}) + sic_pkg::DIV_W'(r6_den);
            r7_dd  <= {r6_den, 1'b0};
            r7_ctl <= r6_ctl;
        end
    end

    assign o_valid = r_v7;
    assign o_ctl   = r7_ctl;
    assign o_nx    = r7_nx;
    assign o_ny    = r7_ny;
    assign o_dd    = r7_dd;

endmodule

`default_nettype wire

### rtl/core/sic_div.sv
// Pipelined restoring divider, one quotient bit per stage, x and y lanes on one divisor.
`default_nettype none

module sic_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire sic_pkg::t_ctl                  i_ctl,
    input  wire logic [sic_pkg::DIV_W-1:0]      i_nx,
    input  wire logic [sic_pkg::DIV_W-1:0]      i_ny,
    input  wire logic [sic_pkg::DD_W-1:0]       i_dd,
    output logic                                o_valid,
    output sic_pkg::t_ctl                       o_ctl,
    output logic [sic_pkg::Q_W-1:0]             o_qx,
    output logic [sic_pkg::Q_W-1:0]             o_qy
);

    logic                        r_v  [sic_pkg::DIV_STAGES];
    sic_pkg::t_ctl               r_ctl[sic_pkg::DIV_STAGES];
    logic [sic_pkg::DIV_W-1:0]   r_rx [sic_pkg::DIV_STAGES];
    logic [sic_pkg::DIV_W-1:0]   r_ry [sic_pkg::DIV_STAGES];
    logic [sic_pkg::QB-1:0]      r_qx [sic_pkg::DIV_STAGES];
    logic [sic_pkg::QB-1:0]      r_qy [sic_pkg::DIV_STAGES];
    logic                        r_sx [sic_pkg::DIV_STAGES];
    logic                        r_sy [sic_pkg::DIV_STAGES];
    logic [sic_pkg::DD_W-1:0]    r_dd [sic_pkg::DIV_STAGES];

    // stage sources: the module input for the first stage, the previous stage otherwise
    sic_pkg::t_ctl               s_ctl[sic_pkg::DIV_STAGES];
    logic [sic_pkg::DIV_W-1:0]   s_rx [sic_pkg::DIV_STAGES];
    logic [sic_pkg::DIV_W-1:0]   s_ry [sic_pkg::DIV_STAGES];
    logic [sic_pkg::QB-1:0]      s_qx [sic_pkg::DIV_STAGES];
    logic [sic_pkg::QB-1:0]      s_qy [sic_pkg::DIV_STAGES];
    logic                        s_sx [sic_pkg::DIV_STAGES];
    logic                        s_sy [sic_pkg::DIV_STAGES];
    logic [sic_pkg::DD_W-1:0]    s_dd [sic_pkg::DIV_STAGES];

    logic [sic_pkg::DIV_W-1:0]   n_rx [sic_pkg::DIV_STAGES];
    logic [sic_pkg::DIV_W-1:0]   n_ry [sic_pkg::DIV_STAGES];
    logic [sic_pkg::QB-1:0]      n_qx [sic_pkg::DIV_STAGES];
    logic [sic_pkg::QB-1:0]      n_qy [sic_pkg::DIV_STAGES];
    logic                        n_sx [sic_pkg::DIV_STAGES];
    logic                        n_sy [sic_pkg::DIV_STAGES];

    always_comb begin
        s_ctl[0] = i_ctl;
        s_rx[0]  = i_nx;
        s_ry[0]  = i_ny;
        s_qx[0]  = '0;
        s_qy[0]  = '0;
        s_sx[0]  = 1'b0;
        s_sy[0]  = 1'b0;
        s_dd[0]  = i_dd;
        for (int i = 1; i < sic_pkg::DIV_STAGES; i++) begin
            s_ctl[i] = r_ctl[i-1];
            s_rx[i]  = r_rx[i-1];
            s_ry[i]  = r_ry[i-1];
            s_qx[i]  = r_qx[i-1];
            s_qy[i]  = r_qy[i-1];
            s_sx[i]  = r_sx[i-1];
            s_sy[i]  = r_sy[i-1];
            s_dd[i]  = r_dd[i-1];
        end
    end

    always_comb begin
        logic [sic_pkg::DIV_W-1:0] sh;
        logic                      gex;
        logic                      gey;

        for (int i = 0; i < sic_pkg::DIV_STAGES; i++) begin
            sh      = sic_pkg::DIV_W'(s_dd[i]) << (sic_pkg::QB - i);
            gex     = s_rx[i] >= sh;
            gey     = s_ry[i] >= sh;
            n_rx[i] = gex ? s_rx[i] - sh : s_rx[i];
            n_ry[i] = gey ? s_ry[i] - sh : s_ry[i];

            if (i == 0) begin
                // top bit only flags a quotient past the clamp
                n_sx[i] = gex;
                n_sy[i] = gey;
                n_qx[i] = '0;
                n_qy[i] = '0;
            end else begin
                n_sx[i] = s_sx[i];
                n_sy[i] = s_sy[i];
                n_qx[i] = {s_qx[i][sic_pkg::QB-2:0], gex};
                n_qy[i] = {s_qy[i][sic_pkg::QB-2:0], gey};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sic_pkg::DIV_STAGES; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < sic_pkg::DIV_STAGES; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < sic_pkg::DIV_STAGES; i++) begin
                r_ctl[i] <= s_ctl[i];
                r_rx[i]  <= n_rx[i];
                r_ry[i]  <= n_ry[i];
                r_qx[i]  <= n_qx[i];
                r_qy[i]  <= n_qy[i];
                r_sx[i]  <= n_sx[i];
                r_sy[i]  <= n_sy[i];
                r_dd[i]  <= s_dd[i];
            end
        end
    end

    assign o_valid = r_v[sic_pkg::DIV_STAGES-1];
    assign o_ctl   = r_ctl[sic_pkg::DIV_STAGES-1];
    assign o_qx    = r_sx[sic_pkg::DIV_STAGES-1] ? {1'b1, {sic_pkg::QB{1'b0}}}
                                                 : {1'b0, r_qx[sic_pkg::DIV_STAGES-1]};
    assign o_qy    = r_sy[sic_pkg::DIV_STAGES-1] ? {1'b1, {sic_pkg::QB{1'b0}}}
                                                 : {1'b0, r_qy[sic_pkg::DIV_STAGES-1]};

endmodule

`default_nettype wire

### rtl/core/sic_out.sv
// Final stage: signed offset plus start point, saturation, output register and skid buffer.
`default_nettype none

module sic_out (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire sic_pkg::t_ctl                      i_ctl,
    input  wire logic [sic_pkg::Q_W-1:0]            i_qx,
    input  wire logic [sic_pkg::Q_W-1:0]            i_qy,
    input  wire logic                               i_m_tready,
    output logic                                    o_en,
    output logic                                    o_m_tvalid,
    output logic [sic_pkg::OUT_DATA_W-1:0]          o_m_tdata
);

    function automatic logic [sic_pkg::COORD_BITS-1:0] sat_c(
        input logic [sic_pkg::SUM_W-1:0] v
    );
        logic [sic_pkg::SUM_W-sic_pkg::COORD_BITS:0] top;

        top = v[sic_pkg::SUM_W-1:sic_pkg::COORD_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return v[sic_pkg::COORD_BITS-1:0];
        end
        return v[sic_pkg::SUM_W-1] ? {1'b1, {(sic_pkg::COORD_BITS-1){1'b0}}}
                                   : {1'b0, {(sic_pkg::COORD_BITS-1){1'b1}}};
    endfunction

    logic                           r_fv;
    logic [sic_pkg::SUM_W-1:0]      r_sum_x, r_sum_y;
    sic_pkg::t_hit_class            r_cls;
    logic                           r_give;

    logic                           r_out_valid;
    logic [sic_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_sk_valid;
    logic [sic_pkg::OUT_DATA_W-1:0] r_sk_data;

    logic [sic_pkg::SUM_W-1:0]      n_sum_x, n_sum_y;
    logic [sic_pkg::OUT_DATA_W-1:0] res;
    logic                           en;
    logic                           push;
    logic                           pop;

    always_comb begin
        logic [sic_pkg::SUM_W-1:0] qx;
        logic [sic_pkg::SUM_W-1:0] qy;
        logic [sic_pkg::SUM_W-1:0] bx;
        logic [sic_pkg::SUM_W-1:0] by;

        qx = sic_pkg::SUM_W'(i_qx);
        qy = sic_pkg::SUM_W'(i_qy);
        bx = sic_pkg::SUM_W'(i_ctl.ax1);
        by = sic_pkg::SUM_W'(i_ctl.ay1);
        n_sum_x = bx + (i_ctl.neg_x ? -qx : qx);
        n_sum_y = by + (i_ctl.neg_y ? -qy : qy);
    end

    // withheld points read as zero
    assign res = sic_pkg::OUT_DATA_W'({
        r_give ? sat_c(r_sum_y) : {sic_pkg::COORD_BITS{1'b0}},
        r_give ? sat_c(r_sum_x) : {sic_pkg::COORD_BITS{1'b0}},
        r_cls
    });

    assign en   = !r_sk_valid;
    assign push = en && r_fv;
    assign pop  = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            if (en) begin
                r_fv <= i_valid;
            end
            if (r_sk_valid) begin
                if (i_m_tready) begin
                    r_sk_valid <= 1'b0;
                end
            end else if (push) begin
                if (!r_out_valid || i_m_tready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_sk_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_cls   <= i_ctl.cls;
            r_give  <= i_ctl.give;
        end
        if (r_sk_valid && i_m_tready) begin
            r_out_data <= r_sk_data;
        end else if (push && (!r_out_valid || i_m_tready)) begin
            r_out_data <= res;
        end
        // park the result while the output register is stalled
        if (push && r_out_valid && !i_m_tready) begin
            r_sk_data <= res;
        end
    end

    assign o_en       = en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

### rtl/core/sic_checker.sv
// Port-level checker for the segment intersection classifier, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module sic_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    input  wire logic                               o_s_tready,
    input  wire logic [sic_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  wire logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    input  wire logic [sic_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    logic                       cls_none;
    logic                       point_zero;
    logic                       in_seen;

    assign cls_none   = o_m_tdata[1:0] == sic_pkg::CLS_NONE;
    assign point_zero = o_m_tdata[2*sic_pkg::COORD_BITS+1:2] == '0;
    assign in_seen    = i_s_tvalid && (i_s_tdata != '0 || i_s_tdata == '0);

    // a reset cycle leaves no result pending
    `SIC_ASSERT(a_reset_clears, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    `SIC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // parallel or degenerate pairs never carry a point
    `SIC_ASSERT_RST(a_none_zero, i_clk, i_rst_n, o_m_tvalid && cls_none |-> point_zero, "point given for class none")

    // input side closes only after the output side stalled
    `SIC_ASSERT_RST(a_ready_fall, i_clk, i_rst_n, $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready && (in_seen || !in_seen)), "ready dropped without output stall")

    `SIC_ASSERT_RST(a_skid_full, i_clk, i_rst_n, !o_s_tready |-> o_m_tvalid, "input held off with no result shown")

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (.*);

`default_nettype wire

### test/sic_stream_checker.sv
// Stream checker for the segment intersection classifier: predicts each result and compares.
`timescale 1ns / 1ps

module sic_stream_checker
    import sic_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    input  logic                    i_s_tready,
    input  logic [IN_DATA_W-1:0]    i_s_tdata,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [OUT_DATA_W-1:0]   i_m_tdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int CW = COORD_BITS;

    typedef struct {
        t_hit_class             cls;
        logic signed [CW-1:0]   px;
        logic signed [CW-1:0]   py;
    } t_crossing;

    t_crossing crossing_q[$];
    t_crossing got;
    t_crossing want;
    int result_idx;

    // num/den within [0,1], both ends included
    function automatic logic in_unit(input longint num, input longint den);
        if (den > 0) begin
            return num >= 0 && num <= den;
        end
        return num <= 0 && num >= den;
    endfunction

    // nearest integer, halves away from zero
    function automatic longint round_div(input longint p, input longint d);
        longint unsigned up;
        longint unsigned ud;
        longint unsigned q;
        up = (p < 0) ? -p : p;
        ud = (d < 0) ? -d : d;
        q = (2 * up + ud) / (2 * ud);
        return ((p < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi[CW-1:0];
        end
        if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic t_crossing predict_crossing(input logic [IN_DATA_W-1:0] d);
        logic signed [CW-1:0] c [8];
        longint ax1, ay1, bx1, by1;
        longint ax, ay, bx, by, cx, cy;
        longint den, num_a, num_b;
        t_mode mode;
        logic give;
        t_crossing r;
        for (int i = 0; i < 8; i++) begin
            c[i] = d[i*CW +: CW];
        end
        mode = d[8*CW +: 2];
        ax1 = c[0];
        ay1 = c[1];
        bx1 = c[4];
        by1 = c[5];
        ax = c[2] - ax1;
        ay = c[3] - ay1;
        bx = bx1 - c[6];
        by = by1 - c[7];
        cx = ax1 - bx1;
        cy = ay1 - by1;
        r.cls = CLS_NONE;
        r.px = '0;
        r.py = '0;
        den = ay * bx - ax * by;
        if (den != 0) begin
            num_a = by * cx - bx * cy;
            num_b = ax * cy - ay * cx;
            r.cls = (in_unit(num_a, den) && in_unit(num_b, den)) ? CLS_HIT : CLS_OUTSIDE;
            // unused mode code behaves as within-only
            give = (mode == MODE_ALWAYS) || (mode != MODE_NONE && r.cls == CLS_HIT);
            if (give) begin
                r.px = clamp_coord(ax1 + round_div(ax * num_a, den));
                r.py = clamp_coord(ay1 + round_div(ay * num_a, den));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
        $display("result %0d: %s mismatch, got %0d, want %0d", result_idx, what, got_v, want_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                crossing_q.push_back(predict_crossing(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.cls = t_hit_class'(i_m_tdata[1:0]);
                got.px = i_m_tdata[2 +: CW];
                got.py = i_m_tdata[2 + CW +: CW];
                if (crossing_q.size() == 0) begin
                    report_mismatch("unrequested result class", longint'(got.cls), -64'sd1);
                end else begin
                    want = crossing_q.pop_front();
                    if (got.cls != want.cls) begin
                        report_mismatch("hit_class", longint'(got.cls), longint'(want.cls));
                    end
                    if (got.px != want.px) begin
                        report_mismatch("point_x", longint'(got.px), longint'(want.px));
                    end
                    if (got.py != want.py) begin
                        report_mismatch("point_y", longint'(got.py), longint'(want.py));
                    end
                    if (i_m_tdata[OUT_DATA_W-1:2 + 2*CW] != '0) begin
                        report_mismatch("pad", longint'(i_m_tdata[OUT_DATA_W-1:2 + 2*CW]),
                                        64'sd0);
                    end
                end
                result_idx++;
            end
            o_pending <= crossing_q.size();
        end
    end

endmodule

### test/tb.sv
// Testbench top for the segment intersection classifier: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb;
    import sic_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_PAIRS = 450;

    // first field in the lowest bits
    typedef struct packed {
        logic [IN_DATA_W-8*COORD_BITS-3:0] pad;
        t_mode                      mode;
        logic signed [15:0]         b_y2;
        logic signed [15:0]         b_x2;
        logic signed [15:0]         b_y1;
        logic signed [15:0]         b_x1;
        logic signed [15:0]         a_y2;
        logic signed [15:0]         a_x2;
        logic signed [15:0]         a_y1;
        logic signed [15:0]         a_x1;
    } t_seg_pair;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    int                     fail_count;
    int                     pending;
    int                     tx_idle_pct = 37;
    int                     rx_idle_pct = 51;
    int                     quiet_cycles = 0;

    always #1 clk = ~clk;

    segment_intersection_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    sic_stream_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("segment_intersection_classifier regression: fail");
            $finish;
        end
    end

    function automatic int span(input int lo, input int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(4))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return span(-32768, 32767);
        endcase
    endfunction

    function automatic t_seg_pair make_pair(input int ax1, input int ay1, input int ax2,
                                            input int ay2, input int bx1, input int by1,
                                            input int bx2, input int by2, input t_mode mode);
        t_seg_pair p;
        p = '0;
        p.a_x1 = 16'(ax1);
        p.a_y1 = 16'(ay1);
        p.a_x2 = 16'(ax2);
        p.a_y2 = 16'(ay2);
        p.b_x1 = 16'(bx1);
        p.b_y1 = 16'(by1);
        p.b_x2 = 16'(bx2);
        p.b_y2 = 16'(by2);
        p.mode = mode;
        return p;
    endfunction

    function automatic t_seg_pair rand_pair();
        t_seg_pair p;
        int cx, cy, dx, dy, k;
        p = make_pair(extreme_coord(), span(-32768, 32767), span(-32768, 32767),
                      span(-32768, 32767), span(-32768, 32767), span(-32768, 32767),
                      span(-32768, 32767), span(-32768, 32767), t_mode'($urandom_range(3)));
        case ($urandom_range(9))
            0, 1: begin
                p.a_x1 = 16'(span(-32768, 32767));
            end
            2, 3, 4, 5: begin
                // clustered ends so crossings land inside often
                cx = span(-30000, 30000);
                cy = span(-30000, 30000);
                p.a_x1 = 16'(cx + span(-256, 256));
                p.a_y1 = 16'(cy + span(-256, 256));
                p.a_x2 = 16'(cx + span(-256, 256));
                p.a_y2 = 16'(cy + span(-256, 256));
                p.b_x1 = 16'(cx + span(-256, 256));
                p.b_y1 = 16'(cy + span(-256, 256));
                p.b_x2 = 16'(cx + span(-256, 256));
                p.b_y2 = 16'(cy + span(-256, 256));
            end
            6: begin
                dx = span(-1000, 1000);
                dy = span(-1000, 1000);
                k = span(-3, 3);
                p.a_x1 = 16'(span(-10000, 10000));
                p.a_y1 = 16'(span(-10000, 10000));
                p.a_x2 = 16'(p.a_x1 + dx);
                p.a_y2 = 16'(p.a_y1 + dy);
                p.b_x1 = 16'(span(-10000, 10000));
                p.b_y1 = 16'(span(-10000, 10000));
                p.b_x2 = 16'(p.b_x1 + k * dx);
                p.b_y2 = 16'(p.b_y1 + k * dy);
            end
            7: begin
                if ($urandom_range(1)) begin
                    p.a_x2 = p.a_x1;
                    p.a_y2 = p.a_y1;
                end else begin
                    p.b_x2 = p.b_x1;
                    p.b_y2 = p.b_y1;
                end
            end
            8: begin
                // start B on an end or the midpoint of A
                dx = span(-2000, 2000);
                dy = span(-2000, 2000);
                p.a_x1 = 16'(span(-20000, 20000));
                p.a_y1 = 16'(span(-20000, 20000));
                p.a_x2 = 16'(p.a_x1 + 2 * dx);
                p.a_y2 = 16'(p.a_y1 + 2 * dy);
                k = $urandom_range(2);
                p.b_x1 = 16'(p.a_x1 + k * dx);
                p.b_y1 = 16'(p.a_y1 + k * dy);
                p.b_x2 = 16'(p.b_x1 + span(-2000, 2000));
                p.b_y2 = 16'(p.b_y1 + span(-2000, 2000));
            end
            default: begin
                p.a_y1 = 16'(extreme_coord());
                p.a_x2 = 16'(extreme_coord());
                p.a_y2 = 16'(extreme_coord());
                p.b_x1 = 16'(extreme_coord());
                p.b_y1 = 16'(extreme_coord());
                p.b_x2 = 16'(extreme_coord());
                p.b_y2 = 16'(extreme_coord());
            end
        endcase
        return p;
    endfunction

    task automatic send_pair(input t_seg_pair p);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = p;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
    endtask

    // hold the sender until every request has its result
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // crossing at the middle, every point mode
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, MODE_WITHIN));
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, MODE_NONE));
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, MODE_ALWAYS));
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, t_mode'(3)));
        // lines cross beyond segment A
        send_pair(make_pair(0, 0, 16, 16, 64, 0, 0, 64, MODE_WITHIN));
        send_pair(make_pair(0, 0, 16, 16, 64, 0, 0, 64, MODE_ALWAYS));
        send_pair(make_pair(0, 0, 16, 16, 64, 0, 0, 64, t_mode'(3)));
        // parallel, collinear, degenerate
        send_pair(make_pair(0, 0, 16, 16, 16, 0, 32, 16, MODE_ALWAYS));
        send_pair(make_pair(0, 0, 32, 32, 16, 16, 48, 48, MODE_ALWAYS));
        send_pair(make_pair(5, 5, 5, 5, 0, 16, 32, -16, MODE_ALWAYS));
        send_pair(make_pair(5, 5, 5, 5, 7, 7, 7, 7, MODE_ALWAYS));
        // touching at the ends of the unit range
        send_pair(make_pair(0, 0, 32, 0, 0, -16, 0, 16, MODE_WITHIN));
        send_pair(make_pair(0, 0, 32, 0, 32, -16, 32, 16, MODE_WITHIN));
        send_pair(make_pair(0, 0, 32, 0, 16, 0, 16, 32, MODE_WITHIN));
        send_pair(make_pair(0, 0, 32, 0, 16, 32, 16, 0, MODE_WITHIN));
        // field extremes
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, MODE_ALWAYS));
        send_pair(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            MODE_ALWAYS));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                            MODE_WITHIN));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767,
                            MODE_ALWAYS));
        // nearly parallel lines meet far off, point saturates
        send_pair(make_pair(-32768, 0, 32767, 1, -32768, 2, 32767, 4, MODE_ALWAYS));
        send_pair(make_pair(32767, 0, -32768, 1, 32767, 2, -32768, 4, MODE_ALWAYS));
        send_pair(make_pair(0, -32768, 1, 32767, 2, -32768, 4, 32767, MODE_ALWAYS));
        // half-way rounding on both signs
        send_pair(make_pair(0, 0, 1, 1, 0, 1, 1, 0, MODE_WITHIN));
        send_pair(make_pair(0, 0, -1, -1, 0, -1, -1, 0, MODE_WITHIN));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 51;
                end
                1: begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 37;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                send_pair(rand_pair());
            end
            drain();
        end

        // let any stray result surface
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("segment_intersection_classifier regression: pass");
        end else begin
            $display("segment_intersection_classifier regression: fail");
        end
        $finish;
    end

endmodule
